// File: sv/bls_pkg.sv
// Shared types and constants of the audio block level meter.
package bls_pkg;

	localparam int SAMPLE_W = 24;
	localparam int MAX_BLOCK = 4096;
	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W - 1;
	localparam int SQ_W = 2 * SAMPLE_W + CNT_W - 2;
	localparam int MEAN_W = 32;
	localparam int MEAN_FRAC = 8;
	localparam int DIV_STEPS = SQ_W;
	localparam int ROOT_STEPS = (SQ_W + 1) / 2;
	localparam int RAD_W = 2 * ROOT_STEPS;
	localparam int RREM_W = ROOT_STEPS + 3;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic signed [SAMPLE_W-1:0] CLIP_HI = 24'sd8388606;
	localparam logic signed [SAMPLE_W-1:0] CLIP_LO = -24'sd8388606;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic last;
	} in_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_q8;
		logic [SAMPLE_W-1:0] rms_level;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SAMPLE_W-1:0] max_value;
		logic [CNT_W-1:0] clip_total;
		logic [CNT_W-1:0] sample_total;
		logic overflow;
	} out_t;

	typedef struct packed {
		logic acc;
		logic snap;
		logic div_step;
		logic ld_sq;
		logic ld_rt;
		logic rt_step;
		logic out_load;
	} cmd_t;

endpackage

// File: sv/bls_if.sv
// Valid/ready channel interfaces for samples and block results.
interface bls_in_if;
	logic valid;
	logic ready;
	bls_pkg::in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bls_out_if;
	logic valid;
	logic ready;
	bls_pkg::out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/bls_ctrl.sv
// Controller state machine that sequences accumulation, division, square root and output.
module bls_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	output bls_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_SNAP = 3'd1;
	localparam logic [2:0] ST_DIVM = 3'd2;
	localparam logic [2:0] ST_LDSQ = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_LDRT = 3'd5;
	localparam logic [2:0] ST_ROOT = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [bls_pkg::STEP_W-1:0] DIV_LAST =
		bls_pkg::STEP_W'(bls_pkg::DIV_STEPS - 1);
	localparam logic [bls_pkg::STEP_W-1:0] ROOT_LAST =
		bls_pkg::STEP_W'(bls_pkg::ROOT_STEPS - 1);

	logic [2:0] state_q;
	logic [bls_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;
	logic in_xfer;

	assign in_ready = (state_q == ST_ACC);
	assign in_xfer = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.acc = in_xfer;
		cmd.snap = (state_q == ST_SNAP);
		cmd.div_step = (state_q == ST_DIVM) || (state_q == ST_DIVS);
		cmd.ld_sq = (state_q == ST_LDSQ);
		cmd.ld_rt = (state_q == ST_LDRT);
		cmd.rt_step = (state_q == ST_ROOT);
		cmd.out_load = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (in_xfer && in_last) begin
						state_q <= ST_SNAP;
					end
				end
				ST_SNAP: begin
					step_q <= '0;
					state_q <= ST_DIVM;
				end
				ST_DIVM: begin
					if (step_q == DIV_LAST) begin
						step_q <= '0;
						state_q <= ST_LDSQ;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_LDSQ: begin
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					if (step_q == DIV_LAST) begin
						step_q <= '0;
						state_q <= ST_LDRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_LDRT: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (step_q == ROOT_LAST) begin
						step_q <= '0;
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

// File: sv/bls_dp.sv
// Datapath with block accumulators, a radix-2 divider, a square root unit and the result register.
module bls_dp (
	input  logic clk,
	input  logic arst_n,
	input  bls_pkg::cmd_t cmd,
	input  logic signed [bls_pkg::SAMPLE_W-1:0] sample,
	output bls_pkg::out_t result
);

	localparam int SW = bls_pkg::SAMPLE_W;
	localparam int CW = bls_pkg::CNT_W;
	localparam int SUMW = bls_pkg::SUM_W;
	localparam int SQW = bls_pkg::SQ_W;
	localparam int MW = bls_pkg::MEAN_W;
	localparam int RSTEPS = bls_pkg::ROOT_STEPS;
	localparam int RADW = bls_pkg::RAD_W;
	localparam int RRW = bls_pkg::RREM_W;

	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0] sq_q;
	logic signed [SW-1:0] min_q;
	logic signed [SW-1:0] max_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] clip_q;
	logic ovf_q;

	logic signed [SW-1:0] blk_min_q;
	logic signed [SW-1:0] blk_max_q;
	logic [CW-1:0] blk_cnt_q;
	logic [CW-1:0] blk_clip_q;
	logic blk_ovf_q;
	logic blk_neg_q;
	logic [SQW-1:0] sq_hold_q;
	logic [SQW-1:0] dvd_q;
	logic [CW-1:0] rem_q;
	logic signed [MW-1:0] mean_q;
	logic [RADW-1:0] rad_q;
	logic [RRW-1:0] rrem_q;
	logic [RSTEPS-1:0] root_q;
	bls_pkg::out_t result_q;

	logic full;
	logic clipped;
	logic signed [2*SW-1:0] square;
	logic [SUMW-1:0] abs_sum;
	logic [CW:0] rem_try;
	logic [CW:0] rem_diff;
	logic q_bit;
	logic [RRW-1:0] rt_try;
	logic [RRW-1:0] rt_trial;
	logic rt_bit;

	assign full = (cnt_q >= CW'(bls_pkg::MAX_BLOCK));
	assign clipped = (sample >= bls_pkg::CLIP_HI) || (sample <= bls_pkg::CLIP_LO);
	assign square = sample * sample;
	assign abs_sum = sum_q[SUMW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

	assign rem_try = {rem_q, dvd_q[SQW-1]};
	assign rem_diff = rem_try - {1'b0, blk_cnt_q};
	assign q_bit = (rem_try >= {1'b0, blk_cnt_q});

	assign rt_try = {rrem_q[RRW-3:0], rad_q[RADW-1:RADW-2]};
	assign rt_trial = {1'b0, root_q, 2'b01};
	assign rt_bit = (rt_try >= rt_trial);

	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q <= '0;
			cnt_q <= '0;
			clip_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.snap) begin
			sum_q <= '0;
			sq_q <= '0;
			cnt_q <= '0;
			clip_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_q + SUMW'(sample);
				sq_q <= sq_q + SQW'($unsigned(square));
				cnt_q <= cnt_q + 1'b1;
				if (clipped) begin
					clip_q <= clip_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && !full) begin
			if (cnt_q == '0) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			blk_min_q <= min_q;
			blk_max_q <= max_q;
			blk_cnt_q <= cnt_q;
			blk_clip_q <= clip_q;
			blk_ovf_q <= ovf_q;
			blk_neg_q <= sum_q[SUMW-1];
			sq_hold_q <= sq_q;
			dvd_q <= SQW'({abs_sum, {bls_pkg::MEAN_FRAC{1'b0}}});
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SQW-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[CW-1:0] : rem_try[CW-1:0];
		end else if (cmd.ld_sq) begin
			mean_q <= blk_neg_q ? -$signed(dvd_q[MW-1:0]) : $signed(dvd_q[MW-1:0]);
			dvd_q <= sq_hold_q;
			rem_q <= '0;
		end else if (cmd.ld_rt) begin
			rad_q <= RADW'(dvd_q);
			rrem_q <= '0;
			root_q <= '0;
		end else if (cmd.rt_step) begin
			rad_q <= {rad_q[RADW-3:0], 2'b00};
			rrem_q <= rt_bit ? (rt_try - rt_trial) : rt_try;
			root_q <= {root_q[RSTEPS-2:0], rt_bit};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.mean_q8 <= mean_q;
			result_q.rms_level <= root_q[SW-1:0];
			result_q.min_value <= blk_min_q;
			result_q.max_value <= blk_max_q;
			result_q.clip_total <= blk_clip_q;
			result_q.sample_total <= blk_cnt_q;
			result_q.overflow <= blk_ovf_q;
		end
	end

endmodule

// File: sv/audio_block_level_stats_top.sv
// Top level of the audio block level meter.
// Samples that do not end a block are taken one per cycle while the controller is in its accumulate state.
// A sample marked last is followed by a snapshot, two 59-step divisions by the
// sample count in one shared divider and a 30-step square root.
// The result then waits in the output register while new samples are taken.
// Reset clears the sum, square, count, clip and overflow accumulators, the controller and the output valid flag.
module audio_block_level_stats_top (
	input  logic clk,
	input  logic arst_n,
	bls_in_if.sink samples,
	bls_out_if.source results
);

	bls_pkg::cmd_t cmd;

	bls_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples.valid),
		.in_last(samples.data.last),
		.in_ready(samples.ready),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.cmd(cmd)
	);

	bls_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sample(samples.data.sample),
		.result(results.data)
	);

endmodule
